>>> rtl/thcb_pkg.sv
// thcb_pkg: types, codes and checksum helpers shared by the header builder
// used by thcb_front, thcb_queue, thcb_back and the top level
package thcb_pkg;

    localparam int DEF_MAX_PAYLOAD = 1024;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic       MODE_DESC     = 1'b0;
    localparam logic       MODE_BYTE     = 1'b1;

    localparam logic [1:0] KIND_UDP      = 2'd0;
    localparam logic [1:0] KIND_TCP_DATA = 2'd1;
    localparam logic [1:0] KIND_TCP_FIN  = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic       STATUS_OK       = 1'b0;
    localparam logic       STATUS_TOO_LONG = 1'b1;

    localparam logic [7:0]  FLAGS_ACK_PSH = 8'h18;
    localparam logic [7:0]  FLAGS_ACK_FIN = 8'h11;
    localparam logic [15:0] TCP_OFFSET    = 16'((5 << 4) << 8);
    localparam logic [15:0] TCP_WINDOW    = 16'hFFFF;
    localparam logic [15:0] TCP_PROTOCOL  = 16'd6;
    localparam logic [15:0] HDR_LEN_TCP   = 16'd20;
    localparam logic [15:0] HDR_LEN_UDP   = 16'd8;

    localparam logic [3:0] POS_LAST_UDP = 4'd3;
    localparam logic [3:0] POS_CSUM     = 4'd8;
    localparam logic [3:0] POS_LAST_TCP = 4'd9;

    typedef struct packed {
        logic        mode;
        logic [1:0]  kind;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [31:0] sequence_number;
        logic [31:0] acknowledge_number;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] header_word;
        logic [3:0]  word_position;
        logic        last_word;
        logic        status;
        logic [31:0] next_sequence;
    } t_result;

    typedef struct packed {
        logic        err;
        logic [1:0]  kind;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] len;
        logic [15:0] psum;
    } t_job;

    // ones' complement add with end-around carry, result stays within 17 bits
    function automatic logic [16:0] fold_add(input logic [16:0] acc, input logic [15:0] w);
        logic [17:0] s;
        s = {1'b0, acc} + {2'b00, w};
        return {1'b0, s[15:0]} + {15'd0, s[17:16]};
    endfunction

    function automatic logic [15:0] fold_final(input logic [16:0] x);
        return x[15:0] + {15'd0, x[16]};
    endfunction

endpackage

>>> rtl/thcb_front.sv
// thcb_front: accepts descriptors and payload bytes, sums the payload
// depends on thcb_pkg; hands finished segments to thcb_queue
module thcb_front import thcb_pkg::*; #(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_job_push,
    output t_job     o_job
);

    logic [15:0] r_remaining, n_remaining;
    logic [16:0] r_acc, n_acc;
    logic [8:0]  r_held, n_held;
    t_job        r_pend, n_pend;

    logic        accept;
    logic [15:0] pair_word;

    assign accept = i_push && !i_q_full;

    always_comb begin
        n_remaining = r_remaining;
        n_acc       = r_acc;
        n_held      = r_held;
        n_pend      = r_pend;
        o_job_push  = 1'b0;
        o_job       = r_pend;
        pair_word   = r_held[8] ? {r_held[7:0], i_item.payload_byte}
                                : {i_item.payload_byte, 8'h00};
        if (accept) begin
            if (i_item.mode == MODE_DESC) begin
                n_remaining = '0;
                n_acc       = '0;
                n_held      = '0;
                if (i_item.kind == KIND_NONE) begin
                    n_remaining = '0;
                end else if (i_item.payload_length > 16'(MAX_PAYLOAD)) begin
                    o_job_push = 1'b1;
                    o_job.err  = 1'b1;
                    o_job.seq  = i_item.sequence_number;
                end else begin
                    n_pend.err   = 1'b0;
                    n_pend.kind  = i_item.kind;
                    n_pend.src   = i_item.source_address;
                    n_pend.dst   = i_item.destination_address;
                    n_pend.sport = i_item.source_port;
                    n_pend.dport = i_item.destination_port;
                    n_pend.seq   = i_item.sequence_number;
                    n_pend.ack   = i_item.acknowledge_number;
                    n_pend.len   = i_item.payload_length;
                    n_pend.psum  = '0;
                    if (i_item.payload_length == '0) begin
                        o_job_push = 1'b1;
                        o_job      = n_pend;
                    end else begin
                        n_remaining = i_item.payload_length;
                    end
                end
            end else if (r_remaining != '0) begin
                if (r_held[8]) begin
                    n_acc  = fold_add(r_acc, pair_word);
                    n_held = '0;
                end else begin
                    n_held = {1'b1, i_item.payload_byte};
                end
                n_remaining = r_remaining - 16'd1;
                if (r_remaining == 16'd1) begin
                    o_job_push = 1'b1;
                    o_job.psum = fold_final(fold_add(r_acc, pair_word));
                    n_acc      = '0;
                    n_held     = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_acc       <= '0;
            r_held      <= '0;
        end else begin
            r_remaining <= n_remaining;
            r_acc       <= n_acc;
            r_held      <= n_held;
        end
        r_pend <= n_pend;
    end

endmodule

>>> rtl/thcb_queue.sv
// thcb_queue: short queue of finished segments between front and back
// depends on thcb_pkg for the segment type
module thcb_queue import thcb_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_job,
    output logic o_full,
    input  logic i_rd,
    output t_job o_rd_job,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_wr, do_rd;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && !o_empty;
    assign o_rd_job = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_job;
        end
    end

endmodule

>>> rtl/thcb_back.sv
// thcb_back: walks a segment's header words, folds in the tcp checksum
// depends on thcb_pkg; reads thcb_queue and holds the result register
module thcb_back import thcb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_job    i_q_job,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic        r_busy;
    logic [3:0]  r_pos;
    logic [16:0] r_acc;
    t_job        r_job;
    logic        r_out_valid;
    t_result     r_out;

    logic        out_ready, advance, is_last, finish, load;
    logic [15:0] term_a, term_b, word;
    logic [7:0]  flags;
    logic [16:0] n_acc;
    t_result     n_out;

    assign out_ready = !r_out_valid || i_pop;
    assign advance   = r_busy && out_ready;
    assign is_last   = r_job.err || ((r_job.kind == KIND_UDP) ? (r_pos == POS_LAST_UDP)
                                                              : (r_pos == POS_LAST_TCP));
    assign finish    = advance && is_last;
    assign load      = (!r_busy || finish) && !i_q_empty;
    assign o_q_pop   = load;
    assign flags     = (r_job.kind == KIND_TCP_DATA) ? FLAGS_ACK_PSH : FLAGS_ACK_FIN;

    always_comb begin
        term_a = '0;
        term_b = '0;
        case (r_pos)
            4'd0: begin term_a = r_job.src[31:16];  term_b = r_job.src[15:0]; end
            4'd1: begin term_a = r_job.dst[31:16];  term_b = r_job.dst[15:0]; end
            4'd2: begin term_a = TCP_PROTOCOL;      term_b = HDR_LEN_TCP + r_job.len; end
            4'd3: begin term_a = r_job.sport;       term_b = r_job.dport; end
            4'd4: begin term_a = r_job.seq[31:16];  term_b = r_job.seq[15:0]; end
            4'd5: begin term_a = r_job.ack[31:16];  term_b = r_job.ack[15:0]; end
            4'd6: begin term_a = TCP_OFFSET | {8'h00, flags}; term_b = TCP_WINDOW; end
            4'd7: begin term_a = r_job.psum;        term_b = '0; end
            default: begin term_a = '0;             term_b = '0; end
        endcase
        n_acc = fold_add(fold_add(r_acc, term_a), term_b);
    end

    always_comb begin
        word = '0;
        if (r_job.kind == KIND_UDP) begin
            unique case (r_pos)
                4'd0:    word = r_job.sport;
                4'd1:    word = r_job.dport;
                4'd2:    word = HDR_LEN_UDP + r_job.len;
                default: word = '0;
            endcase
        end else begin
            unique case (r_pos)
                4'd0:     word = r_job.sport;
                4'd1:     word = r_job.dport;
                4'd2:     word = r_job.seq[31:16];
                4'd3:     word = r_job.seq[15:0];
                4'd4:     word = r_job.ack[31:16];
                4'd5:     word = r_job.ack[15:0];
                4'd6:     word = TCP_OFFSET | {8'h00, flags};
                4'd7:     word = TCP_WINDOW;
                POS_CSUM: word = ~fold_final(r_acc);
                default:  word = '0;
            endcase
        end
        n_out.header_word   = r_job.err ? 16'd0 : word;
        n_out.word_position = r_job.err ? 4'd0 : r_pos;
        n_out.last_word     = is_last;
        n_out.status        = r_job.err ? STATUS_TOO_LONG : STATUS_OK;
        n_out.next_sequence = r_job.err ? r_job.seq : r_job.seq + {16'd0, r_job.len};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            r_job <= i_q_job;
            r_pos <= '0;
            r_acc <= '0;
        end else if (advance) begin
            r_pos <= r_pos + 4'd1;
            r_acc <= n_acc;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    // an error result is a single word
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == STATUS_TOO_LONG
        |-> r_out.last_word && r_out.word_position == 4'd0)
        else $error("error result is not a single last word");

    // udp never walks past its last word
    a_udp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_job.err && r_job.kind == KIND_UDP |-> r_pos <= POS_LAST_UDP)
        else $error("udp position out of range");

    // a word that is not last means the segment is still being walked
    a_more_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last_word |-> r_busy)
        else $error("segment ended without a last word");

endmodule

>>> rtl/tcp_udp_header_checksum_builder_top.sv
// tcp/udp header builder: one input transfer per cycle while the segment
// queue has room; a finished segment is queued and loaded into the back end's
// job register, then one word per cycle while results are popped (4 udp, 10 tcp),
// limited by the back end's word walk; a running checksum adds two terms a word
// reset is synchronous active low and clears control state at once, no sweep
module tcp_udp_header_checksum_builder_top import thcb_pkg::*; #(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     empty,
    input  logic     pop,
    output t_result  o_result
);

    logic job_push, q_full, q_empty, q_pop;
    t_job job_in, job_out;

    assign full = q_full;

    thcb_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_q_full   (q_full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    thcb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_push),
        .i_wr_job (job_in),
        .o_full   (q_full),
        .i_rd     (q_pop),
        .o_rd_job (job_out),
        .o_empty  (q_empty)
    );

    thcb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (job_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

>>> tb/tcp_udp_header_checksum_builder_top_tb.sv
// testbench for tcp_udp_header_checksum_builder_top: drives segment descriptors and
// payload bytes, predicts every header word and checks each result transfer
// depends on thcb_pkg and the top level rtl
module tcp_udp_header_checksum_builder_top_tb;
    import thcb_pkg::*;

    localparam int MAX_LEN        = DEF_MAX_PAYLOAD;
    localparam int RANDOM_ITEMS   = 280;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 30;
    localparam int IDLE_LIMIT     = 2000;
    localparam int REPORT_LIMIT   = 10;

    logic     i_clk;
    logic     i_rst_n;
    logic     push;
    logic     full;
    t_in_item i_item;
    logic     empty;
    logic     pop;
    t_result  o_result;

    tcp_udp_header_checksum_builder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // builder state as seen from outside
    logic [1:0]  seg_kind;
    logic [31:0] seg_src;
    logic [31:0] seg_dst;
    logic [15:0] seg_sport;
    logic [15:0] seg_dport;
    logic [15:0] seg_len;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] bytes_left;
    logic [31:0] payload_sum;
    logic [8:0]  odd_byte;

    t_result header_words_due[$];

    int  error_count;
    int  words_checked;
    int  udp_headers;
    int  tcp_data_headers;
    int  tcp_fin_headers;
    int  too_long_drops;
    int  idle_cycles;
    int  burst_left;
    bit  steady_push;
    bit  rx_hold_req;

    logic [1:0] seg_kinds[3] = '{KIND_UDP, KIND_TCP_DATA, KIND_TCP_FIN};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ones_add(input logic [31:0] acc, input logic [15:0] w);
        logic [31:0] s;
        s = acc + {16'd0, w};
        return {16'd0, s[15:0]} + (s >> 16);
    endfunction

    task automatic emit_header_words();
        logic [15:0] w[10];
        logic [31:0] acc;
        logic [31:0] nseq;
        t_result     r;
        int          n;
        acc = payload_sum;
        nseq = seg_seq + {16'd0, seg_len};
        if (odd_byte[8])
            acc = ones_add(acc, {odd_byte[7:0], 8'h00});
        odd_byte = '0;
        bytes_left = '0;
        w[0] = seg_sport;
        w[1] = seg_dport;
        if (seg_kind == KIND_UDP) begin
            w[2] = HDR_LEN_UDP + seg_len;
            w[3] = '0;
            n = 4;
            udp_headers++;
        end else begin
            w[2] = seg_seq[31:16];
            w[3] = seg_seq[15:0];
            w[4] = seg_ack[31:16];
            w[5] = seg_ack[15:0];
            w[6] = TCP_OFFSET | {8'h00,
                   (seg_kind == KIND_TCP_DATA) ? FLAGS_ACK_PSH : FLAGS_ACK_FIN};
            w[7] = TCP_WINDOW;
            w[8] = '0;
            w[9] = '0;
            // pseudo-header, then the header itself
            acc = ones_add(acc, seg_src[31:16]);
            acc = ones_add(acc, seg_src[15:0]);
            acc = ones_add(acc, seg_dst[31:16]);
            acc = ones_add(acc, seg_dst[15:0]);
            acc = ones_add(acc, TCP_PROTOCOL);
            acc = ones_add(acc, HDR_LEN_TCP + seg_len);
            for (int i = 0; i < 10; i++)
                acc = ones_add(acc, w[i]);
            acc = {16'd0, acc[15:0]} + (acc >> 16);
            w[8] = ~acc[15:0];
            n = 10;
            if (seg_kind == KIND_TCP_DATA)
                tcp_data_headers++;
            else
                tcp_fin_headers++;
        end
        payload_sum = '0;
        for (int i = 0; i < n; i++) begin
            r.header_word   = w[i];
            r.word_position = 4'(i);
            r.last_word     = (i == n - 1);
            r.status        = STATUS_OK;
            r.next_sequence = nseq;
            header_words_due.push_back(r);
        end
    endtask

    task automatic advance_builder(input t_in_item it);
        t_result r;
        if (it.mode == MODE_DESC) begin
            bytes_left = '0;
            payload_sum = '0;
            odd_byte = '0;
            if (it.kind == KIND_NONE)
                return;
            if (it.payload_length > MAX_LEN) begin
                r.header_word   = '0;
                r.word_position = '0;
                r.last_word     = 1'b1;
                r.status        = STATUS_TOO_LONG;
                r.next_sequence = it.sequence_number;
                header_words_due.push_back(r);
                too_long_drops++;
                return;
            end
            seg_kind  = it.kind;
            seg_src   = it.source_address;
            seg_dst   = it.destination_address;
            seg_sport = it.source_port;
            seg_dport = it.destination_port;
            seg_len   = it.payload_length;
            seg_seq   = it.sequence_number;
            seg_ack   = it.acknowledge_number;
            if (it.payload_length == 0)
                emit_header_words();
            else
                bytes_left = it.payload_length;
        end else begin
            if (bytes_left == 0)
                return;
            if (odd_byte[8]) begin
                payload_sum = ones_add(payload_sum, {odd_byte[7:0], it.payload_byte});
                odd_byte = '0;
            end else begin
                odd_byte = {1'b1, it.payload_byte};
            end
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 0)
                emit_header_words();
        end
    endtask

    function automatic t_in_item desc_item(input logic [1:0] kind, input logic [15:0] len);
        t_in_item it;
        it.mode                = MODE_DESC;
        it.kind                = kind;
        it.source_address      = $urandom;
        it.destination_address = $urandom;
        it.source_port         = 16'($urandom);
        it.destination_port    = 16'($urandom);
        it.sequence_number     = $urandom;
        it.acknowledge_number  = $urandom;
        it.payload_length      = len;
        it.payload_byte        = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item byte_item(input logic [7:0] b);
        t_in_item it;
        it = desc_item(2'($urandom), 16'($urandom));
        it.mode = MODE_BYTE;
        it.payload_byte = b;
        return it;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input t_in_item it);
        if (!steady_push && burst_left == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        push = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (full);
        advance_builder(it);
        @(negedge i_clk);
        push = 1'b0;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_payload(input int n);
        for (int i = 0; i < n; i++)
            send_item(byte_item(8'($urandom)));
    endtask

    task automatic send_segment(input logic [1:0] kind, input int len, input int n_bytes);
        send_item(desc_item(kind, 16'(len)));
        send_payload(n_bytes);
    endtask

    task automatic wait_drained();
        while (header_words_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_directed();
        t_in_item it;
        it = '0;
        it.mode = MODE_DESC;
        it.kind = KIND_UDP;
        send_item(it);
        it = '1;
        it.mode = MODE_DESC;
        it.kind = KIND_TCP_DATA;
        it.payload_length = '0;
        send_item(it);
        send_segment(KIND_TCP_FIN, 0, 0);
        send_item(desc_item(KIND_UDP, 16'd1));
        send_item(byte_item(8'hFF));
        send_item(desc_item(KIND_TCP_DATA, 16'd2));
        send_item(byte_item(8'h00));
        send_item(byte_item(8'hFF));
        // fin carrying an odd payload
        send_segment(KIND_TCP_FIN, 3, 3);
        send_item(desc_item(KIND_TCP_DATA, 16'hFFFF));
        send_item(desc_item(KIND_UDP, 16'(MAX_LEN + 1)));
        send_item(desc_item(KIND_NONE, 16'd0));
        // abandoned by a new descriptor
        send_segment(KIND_TCP_DATA, 4, 2);
        send_segment(KIND_UDP, 1, 1);
        send_item(byte_item(8'h5A));
        // abandoned by a kind that is ignored
        send_segment(KIND_TCP_FIN, 2, 1);
        send_item(desc_item(KIND_NONE, 16'd2));
        send_item(byte_item(8'hA5));
    endtask

    // longest allowed length is taken as a segment, one more is dropped
    task automatic test_max_payload();
        send_segment(KIND_TCP_DATA, MAX_LEN, 5);
        send_segment(KIND_UDP, MAX_LEN, 4);
        send_item(desc_item(KIND_TCP_FIN, 16'(MAX_LEN + 1)));
        send_payload(2);
    endtask

    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        steady_push = 1'b1;
        for (int i = 0; i < 8; i++)
            send_segment(seg_kinds[$urandom_range(0, 2)], 0, 0);
        steady_push = 1'b0;
    endtask

    task automatic test_random();
        int counted;
        int pick;
        int len;
        int n;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                   : $urandom_range(13, 48);
                send_segment(seg_kinds[$urandom_range(0, 2)], len, len);
                counted += len + 1;
            end else if (pick < 78) begin
                send_item(desc_item(seg_kinds[$urandom_range(0, 2)],
                                    16'($urandom_range(MAX_LEN + 1, 65535))));
                counted++;
            end else if (pick < 85) begin
                len = $urandom_range(2, 12);
                n = $urandom_range(0, len - 1);
                send_segment(seg_kinds[$urandom_range(0, 2)], len, n);
                counted += n + 1;
            end else if (pick < 92) begin
                send_item(desc_item(KIND_NONE, 16'($urandom)));
                counted++;
            end else begin
                n = $urandom_range(1, 3);
                send_payload(n);
                counted += n;
            end
        end
    endtask

    // result side stall pattern
    initial begin
        int pattern;
        int phase_left;
        pop = 1'b0;
        pattern = 0;
        phase_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                pop = 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    pattern = $urandom_range(0, 3);
                    phase_left = $urandom_range(20, 100);
                end
                phase_left--;
                case (pattern)
                    0: pop = 1'b1;
                    1: pop = $urandom_range(0, 1);
                    2: pop = (phase_left % 4 == 0);
                    default: pop = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic check_word(input t_result got);
        t_result want;
        if (header_words_due.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t: unexpected result word %h pos %0d last %b status %b seq %h",
                         $time, got.header_word, got.word_position, got.last_word,
                         got.status, got.next_sequence);
            return;
        end
        want = header_words_due.pop_front();
        words_checked++;
        if (got.header_word !== want.header_word || got.word_position !== want.word_position
                || got.last_word !== want.last_word || got.status !== want.status
                || got.next_sequence !== want.next_sequence) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t: exp %h pos %0d last %b status %b seq %h, got %h %0d %b %b %h",
                         $time, want.header_word, want.word_position, want.last_word,
                         want.status, want.next_sequence, got.header_word,
                         got.word_position, got.last_word, got.status, got.next_sequence);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            check_word(o_result);
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        seg_kind = '0;
        seg_src = '0;
        seg_dst = '0;
        seg_sport = '0;
        seg_dport = '0;
        seg_len = '0;
        seg_seq = '0;
        seg_ack = '0;
        bytes_left = '0;
        payload_sum = '0;
        odd_byte = '0;
        error_count = 0;
        words_checked = 0;
        udp_headers = 0;
        tcp_data_headers = 0;
        tcp_fin_headers = 0;
        too_long_drops = 0;
        idle_cycles = 0;
        burst_left = 0;
        steady_push = 1'b0;
        rx_hold_req = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_max_payload();
        test_backpressure();
        test_random();
        wait_drained();

        $display("checked %0d header words: %0d udp, %0d tcp data, %0d tcp fin headers",
                 words_checked, udp_headers, tcp_data_headers, tcp_fin_headers);
        $display("%0d oversize drops, odd and abandoned segments, one long result stall",
                 too_long_drops);
        if (error_count == 0 && header_words_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d errors, %0d words still due", error_count, header_words_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
